[rtl/elastic_disc_collision_unit_defines.svh]
// assertion macros for the disc collision unit
`ifndef ELASTIC_DISC_COLLISION_UNIT_DEFINES_SVH
`define ELASTIC_DISC_COLLISION_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define EDC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define EDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");
`else
`define EDC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define EDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/edc_pkg.sv]
// shared widths, lane codes and types of the disc collision unit
package edc_pkg;

    localparam int WORD_WIDTH  = 32;
    localparam int DIFF_W      = WORD_WIDTH + 1;       // position and velocity differences
    localparam int PROD_W      = 2 * WORD_WIDTH + 2;   // one difference product
    localparam int SUM_W       = 2 * WORD_WIDTH + 3;   // signed dot product
    localparam int MAG_W       = 2 * WORD_WIDTH + 2;   // |dv.d| and d.d
    localparam int K_W         = WORD_WIDTH + 2;       // twice a mass
    localparam int MUL_CHUNK_W = WORD_WIDTH + 1;
    localparam int MUL_CHUNKS  = 3;
    localparam int MUL_A_W     = MUL_CHUNKS * MUL_CHUNK_W;
    localparam int MUL_B_W     = WORD_WIDTH + 2;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int DEN_W       = MUL_A_W;
    localparam int DIV_W       = DEN_W + 1;
    localparam int REM_W       = MUL_P_W + 2;
    localparam int QUO_W       = WORD_WIDTH + 3;
    localparam int RES_W       = WORD_WIDTH + 5;
    localparam int LANES       = 4;

    localparam int LANE_FIRST_X  = 0;
    localparam int LANE_FIRST_Y  = 1;
    localparam int LANE_SECOND_X = 2;
    localparam int LANE_SECOND_Y = 3;

    typedef logic [LANES-1:0][REM_W-1:0] num_t;
    typedef logic [LANES-1:0][QUO_W-1:0] quo_t;

    // per item control and pass-through data that rides beside the arithmetic
    typedef struct packed {
        logic [LANES-1:0][WORD_WIDTH-1:0] vel;
        logic [K_W-1:0]                   k_first;
        logic [K_W-1:0]                   k_second;
        logic                             neg_x;
        logic                             neg_y;
        logic                             apply;
    } side_t;

endpackage

[rtl/edc_pair_if.sv]
// channel carrying one pair of discs into the unit
interface edc_pair_if;
    logic valid;
    logic ready;
    logic        [edc_pkg::WORD_WIDTH-1:0] mass_first;
    logic        [edc_pkg::WORD_WIDTH-1:0] mass_second;
    logic signed [edc_pkg::WORD_WIDTH-1:0] pos_first_x;
    logic signed [edc_pkg::WORD_WIDTH-1:0] pos_first_y;
    logic signed [edc_pkg::WORD_WIDTH-1:0] pos_second_x;
    logic signed [edc_pkg::WORD_WIDTH-1:0] pos_second_y;
    logic signed [edc_pkg::WORD_WIDTH-1:0] vel_first_x;
    logic signed [edc_pkg::WORD_WIDTH-1:0] vel_first_y;
    logic signed [edc_pkg::WORD_WIDTH-1:0] vel_second_x;
    logic signed [edc_pkg::WORD_WIDTH-1:0] vel_second_y;

    modport source (
        output valid, mass_first, mass_second, pos_first_x, pos_first_y,
               pos_second_x, pos_second_y, vel_first_x, vel_first_y,
               vel_second_x, vel_second_y,
        input  ready
    );
    modport sink (
        input  valid, mass_first, mass_second, pos_first_x, pos_first_y,
               pos_second_x, pos_second_y, vel_first_x, vel_first_y,
               vel_second_x, vel_second_y,
        output ready
    );
endinterface

[rtl/edc_resp_if.sv]
// channel carrying the velocities after impact out of the unit
interface edc_resp_if;
    logic valid;
    logic ready;
    logic signed [edc_pkg::WORD_WIDTH-1:0] new_first_x;
    logic signed [edc_pkg::WORD_WIDTH-1:0] new_first_y;
    logic signed [edc_pkg::WORD_WIDTH-1:0] new_second_x;
    logic signed [edc_pkg::WORD_WIDTH-1:0] new_second_y;
    logic impact_applied;
    logic saturated;

    modport source (
        output valid, new_first_x, new_first_y, new_second_x, new_second_y,
               impact_applied, saturated,
        input  ready
    );
    modport sink (
        input  valid, new_first_x, new_first_y, new_second_x, new_second_y,
               impact_applied, saturated,
        output ready
    );
endinterface

[rtl/elastic_disc_collision_unit.sv]
// top level of the elastic disc collision response pipeline
//
//  channel | role | handshake      | contents
//  --------+------+----------------+-------------------------------------------
//  req     | sink | valid / ready  | two masses, two centres, two velocities
//  rsp     | src  | valid / ready  | four new velocity components, two flags
//  cfg     | sink | cfg_we         | approach_only bit, no read-back
//
//  stages: input, products, sums, two multiplier layers that each register
//  partial products and then their sum, divider set-up, one stage per
//  quotient bit in the divider and the output register
//  one pair is taken per cycle while the pipe advances; all stages move together
//  whenever the output register is empty or its transfer completes
//  a stall on rsp holds every stage, so nothing is lost or repeated
//  reset clears the valid bits and sets approach_only to 1
`include "elastic_disc_collision_unit_defines.svh"

module elastic_disc_collision_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    edc_pair_if.sink          req,
    edc_resp_if.source        rsp
);
    localparam int W     = edc_pkg::WORD_WIDTH;
    localparam int DiffW = edc_pkg::DIFF_W;
    localparam int ProdW = edc_pkg::PROD_W;
    localparam int SumW  = edc_pkg::SUM_W;
    localparam int MagW  = edc_pkg::MAG_W;
    localparam int MulAW = edc_pkg::MUL_A_W;
    localparam int MulBW = edc_pkg::MUL_B_W;
    localparam int MulPW = edc_pkg::MUL_P_W;
    localparam int DenW  = edc_pkg::DEN_W;
    localparam int DivW  = edc_pkg::DIV_W;
    localparam int RemW  = edc_pkg::REM_W;
    localparam int ResW  = edc_pkg::RES_W;
    localparam int Lanes = edc_pkg::LANES;

    // configuration
    logic approach_only_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            approach_only_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            approach_only_reg <= cfg_wdata;
        end
    end

    // global advance: the whole pipe moves when the output slot frees up
    logic en;
    logic out_valid_reg;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    // stage 1: differences
    logic                          s1_valid_reg;
    logic signed [DiffW-1:0]       s1_dx_reg, s1_dy_reg, s1_dvx_reg, s1_dvy_reg;
    logic [Lanes-1:0][W-1:0]       s1_vel_reg;
    logic [W-1:0]                  s1_mf_reg, s1_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg  <= {req.pos_second_x[W-1], req.pos_second_x}
                        - {req.pos_first_x[W-1], req.pos_first_x};
            s1_dy_reg  <= {req.pos_second_y[W-1], req.pos_second_y}
                        - {req.pos_first_y[W-1], req.pos_first_y};
            s1_dvx_reg <= {req.vel_second_x[W-1], req.vel_second_x}
                        - {req.vel_first_x[W-1], req.vel_first_x};
            s1_dvy_reg <= {req.vel_second_y[W-1], req.vel_second_y}
                        - {req.vel_first_y[W-1], req.vel_first_y};
            s1_vel_reg[edc_pkg::LANE_FIRST_X]  <= req.vel_first_x;
            s1_vel_reg[edc_pkg::LANE_FIRST_Y]  <= req.vel_first_y;
            s1_vel_reg[edc_pkg::LANE_SECOND_X] <= req.vel_second_x;
            s1_vel_reg[edc_pkg::LANE_SECOND_Y] <= req.vel_second_y;
            s1_mf_reg  <= req.mass_first;
            s1_ms_reg  <= req.mass_second;
        end
    end

    // stage 2: the four difference products, mass sum, magnitudes of d
    logic                          s2_valid_reg;
    logic signed [ProdW-1:0]       s2_pvx_reg, s2_pvy_reg, s2_pdx_reg, s2_pdy_reg;
    logic [Lanes-1:0][W-1:0]       s2_vel_reg;
    logic [W-1:0]                  s2_mf_reg, s2_ms_reg;
    logic [DiffW-1:0]              s2_msum_reg, s2_adx_reg, s2_ady_reg;
    logic                          s2_dx_neg_reg, s2_dy_neg_reg, s2_dnz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pvx_reg    <= s1_dvx_reg * s1_dx_reg;
            s2_pvy_reg    <= s1_dvy_reg * s1_dy_reg;
            s2_pdx_reg    <= s1_dx_reg * s1_dx_reg;
            s2_pdy_reg    <= s1_dy_reg * s1_dy_reg;
            s2_vel_reg    <= s1_vel_reg;
            s2_mf_reg     <= s1_mf_reg;
            s2_ms_reg     <= s1_ms_reg;
            s2_msum_reg   <= {1'b0, s1_mf_reg} + {1'b0, s1_ms_reg};
            s2_adx_reg    <= s1_dx_reg[DiffW-1] ? DiffW'(-s1_dx_reg) : DiffW'(s1_dx_reg);
            s2_ady_reg    <= s1_dy_reg[DiffW-1] ? DiffW'(-s1_dy_reg) : DiffW'(s1_dy_reg);
            s2_dx_neg_reg <= s1_dx_reg[DiffW-1];
            s2_dy_neg_reg <= s1_dy_reg[DiffW-1];
            s2_dnz_reg    <= (|s1_dx_reg) || (|s1_dy_reg);
        end
    end

    // stage 3: dot products and the impulse decision
    logic signed [SumW-1:0] s_dot;
    logic                   s_neg;
    edc_pkg::side_t         s3_side_next;

    assign s_dot = {s2_pvx_reg[ProdW-1], s2_pvx_reg} + {s2_pvy_reg[ProdW-1], s2_pvy_reg};
    assign s_neg = s_dot[SumW-1];

    always_comb
    begin
        s3_side_next.vel      = s2_vel_reg;
        s3_side_next.k_first  = {1'b0, s2_ms_reg, 1'b0};
        s3_side_next.k_second = {1'b0, s2_mf_reg, 1'b0};
        s3_side_next.neg_x    = s_neg ^ s2_dx_neg_reg;
        s3_side_next.neg_y    = s_neg ^ s2_dy_neg_reg;
        // coincident centres, zero mass sum and, in approach_only mode, separating discs pass through
        s3_side_next.apply    = s2_dnz_reg && (s2_msum_reg != '0)
                             && (!approach_only_reg || s_neg);
    end

    logic               s3_valid_reg;
    edc_pkg::side_t     s3_side_reg;
    logic [MagW-1:0]    s3_abs_s_reg, s3_dd_reg;
    logic [DiffW-1:0]   s3_msum_reg, s3_adx_reg, s3_ady_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg  <= s3_side_next;
            s3_abs_s_reg <= s_neg ? MagW'(-s_dot) : MagW'(s_dot);
            s3_dd_reg    <= MagW'(s2_pdx_reg) + MagW'(s2_pdy_reg);
            s3_msum_reg  <= s2_msum_reg;
            s3_adx_reg   <= s2_adx_reg;
            s3_ady_reg   <= s2_ady_reg;
        end
    end

    // first multiplier layer: |s|*|dx|, |s|*|dy| and the denominator
    logic [MulPW-1:0] sdx_prod, sdy_prod, den_prod;

    edc_mul u_mul_sdx (
        .clk (clk),
        .en  (en),
        .a   (MulAW'(s3_abs_s_reg)),
        .b   (MulBW'(s3_adx_reg)),
        .p   (sdx_prod)
    );

    edc_mul u_mul_sdy (
        .clk (clk),
        .en  (en),
        .a   (MulAW'(s3_abs_s_reg)),
        .b   (MulBW'(s3_ady_reg)),
        .p   (sdy_prod)
    );

    edc_mul u_mul_den (
        .clk (clk),
        .en  (en),
        .a   (MulAW'(s3_dd_reg)),
        .b   (MulBW'(s3_msum_reg)),
        .p   (den_prod)
    );

    logic [1:0]     ma_valid_reg;
    edc_pkg::side_t ma_side_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ma_valid_reg <= '0;
        end
        else if (en)
        begin
            ma_valid_reg <= {ma_valid_reg[0], s3_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_side_reg[0] <= s3_side_reg;
            ma_side_reg[1] <= ma_side_reg[0];
        end
    end

    // second multiplier layer: scale by twice the other disc's mass, per lane
    logic [MulPW-1:0] num_prod [Lanes];

    for (genvar l = 0; l < Lanes; l++)
    begin : g_num
        localparam bit IsX     = (l == edc_pkg::LANE_FIRST_X) || (l == edc_pkg::LANE_SECOND_X);
        localparam bit IsFirst = (l == edc_pkg::LANE_FIRST_X) || (l == edc_pkg::LANE_FIRST_Y);

        edc_mul u_mul_num (
            .clk (clk),
            .en  (en),
            .a   (IsX ? sdx_prod[MulAW-1:0] : sdy_prod[MulAW-1:0]),
            .b   (IsFirst ? ma_side_reg[1].k_first : ma_side_reg[1].k_second),
            .p   (num_prod[l])
        );
    end

    logic [1:0]     mb_valid_reg;
    edc_pkg::side_t mb_side_reg [2];
    logic [DenW-1:0] mb_den_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mb_valid_reg <= '0;
        end
        else if (en)
        begin
            mb_valid_reg <= {mb_valid_reg[0], ma_valid_reg[1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mb_side_reg[0] <= ma_side_reg[1];
            mb_side_reg[1] <= mb_side_reg[0];
            mb_den_reg[0]  <= den_prod[DenW-1:0];
            mb_den_reg[1]  <= mb_den_reg[0];
        end
    end

    // stage 4: round half away from zero as floor((2n + den) / 2den)
    logic            s4_valid_reg;
    edc_pkg::side_t  s4_side_reg;
    edc_pkg::num_t   s4_num_reg;
    edc_pkg::num_t   s4_num_next;
    logic [DivW-1:0] s4_div_reg;

    always_comb
    begin
        for (int l = 0; l < Lanes; l++)
        begin
            s4_num_next[l] = (RemW'(num_prod[l]) << 1) + RemW'(mb_den_reg[1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= mb_valid_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= mb_side_reg[1];
            s4_num_reg  <= s4_num_next;
            s4_div_reg  <= {mb_den_reg[1], 1'b0};
        end
    end

    // divider
    logic           div_valid;
    edc_pkg::side_t div_side;
    edc_pkg::quo_t  div_quo;

    edc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .in_side   (s4_side_reg),
        .in_num    (s4_num_reg),
        .in_div    (s4_div_reg),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quo   (div_quo)
    );

    // output stage: apply signed impulse, saturate to the word range
    logic [Lanes-1:0][W-1:0] out_vel_reg, out_vel_next;
    logic                    out_apply_reg;
    logic                    out_sat_reg, out_sat_next;

    always_comb
    begin
        logic signed [ResW-1:0] mag;
        logic signed [ResW-1:0] delta;
        logic signed [ResW-1:0] vext;
        logic signed [ResW-1:0] sum;
        logic [ResW-W:0]        top;
        logic                   neg;
        out_sat_next = 1'b0;
        for (int l = 0; l < Lanes; l++)
        begin
            neg   = ((l == edc_pkg::LANE_FIRST_X) || (l == edc_pkg::LANE_SECOND_X))
                  ? div_side.neg_x : div_side.neg_y;
            mag   = ResW'(div_quo[l]);
            delta = neg ? -mag : mag;
            if (!div_side.apply)
            begin
                delta = '0;
            end
            vext  = ResW'($signed(div_side.vel[l]));
            if ((l == edc_pkg::LANE_FIRST_X) || (l == edc_pkg::LANE_FIRST_Y))
            begin
                sum = vext + delta;
            end
            else
            begin
                sum = vext - delta;
            end
            top = sum[ResW-1:W-1];
            if ((&top) || !(|top))
            begin
                out_vel_next[l] = sum[W-1:0];
            end
            else
            begin
                out_sat_next    = 1'b1;
                out_vel_next[l] = sum[ResW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_vel_reg   <= out_vel_next;
            out_apply_reg <= div_side.apply;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.new_first_x    = $signed(out_vel_reg[edc_pkg::LANE_FIRST_X]);
    assign rsp.new_first_y    = $signed(out_vel_reg[edc_pkg::LANE_FIRST_Y]);
    assign rsp.new_second_x   = $signed(out_vel_reg[edc_pkg::LANE_SECOND_X]);
    assign rsp.new_second_y   = $signed(out_vel_reg[edc_pkg::LANE_SECOND_Y]);
    assign rsp.impact_applied = out_apply_reg;
    assign rsp.saturated      = out_sat_reg;

    // checks
    `EDC_ASSERT_IMPLIES(a_pass_never_clamps, clk, rst_n, rsp.valid && !rsp.impact_applied, !rsp.saturated)
    `EDC_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, !req.ready, rsp.valid)
    `EDC_ASSERT_IMPLIES(a_quotient_in_range, clk, rst_n, div_valid && div_side.apply, !div_quo[edc_pkg::LANE_FIRST_X][edc_pkg::QUO_W-1] && !div_quo[edc_pkg::LANE_FIRST_Y][edc_pkg::QUO_W-1] && !div_quo[edc_pkg::LANE_SECOND_X][edc_pkg::QUO_W-1] && !div_quo[edc_pkg::LANE_SECOND_Y][edc_pkg::QUO_W-1])
    `EDC_ASSERT_NEXT(a_stall_holds_result, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.impact_applied))

endmodule

[rtl/edc_mul.sv]
// two stage unsigned multiplier built from registered partial products
module edc_mul (
    input  logic                         clk,
    input  logic                         en,
    input  logic [edc_pkg::MUL_A_W-1:0]  a,
    input  logic [edc_pkg::MUL_B_W-1:0]  b,
    output logic [edc_pkg::MUL_P_W-1:0]  p
);
    localparam int ChunkW = edc_pkg::MUL_CHUNK_W;
    localparam int Chunks = edc_pkg::MUL_CHUNKS;
    localparam int PartW  = edc_pkg::MUL_CHUNK_W + edc_pkg::MUL_B_W;
    localparam int ProdW  = edc_pkg::MUL_P_W;

    logic [PartW-1:0] part_reg  [Chunks];
    logic [PartW-1:0] part_next [Chunks];
    logic [ProdW-1:0] p_reg;
    logic [ProdW-1:0] p_next;

    always_comb
    begin
        for (int c = 0; c < Chunks; c++)
        begin
            part_next[c] = PartW'(a[c*ChunkW +: ChunkW]) * PartW'(b);
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int c = 0; c < Chunks; c++)
        begin
            p_next = p_next + (ProdW'(part_reg[c]) << (c * ChunkW));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            part_reg <= part_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;
endmodule

[rtl/edc_div.sv]
// pipelined restoring divider, one quotient bit per stage, four lanes sharing a divisor
module edc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  edc_pkg::side_t              in_side,
    input  edc_pkg::num_t               in_num,
    input  logic [edc_pkg::DIV_W-1:0]   in_div,
    output logic                        out_valid,
    output edc_pkg::side_t              out_side,
    output edc_pkg::quo_t               out_quo
);
    localparam int Stages = edc_pkg::QUO_W;
    localparam int RemW   = edc_pkg::REM_W;
    localparam int DivW   = edc_pkg::DIV_W;

    logic [Stages-1:0] valid_reg;
    edc_pkg::side_t    side_reg [Stages];
    edc_pkg::quo_t     quo_reg  [Stages];
    edc_pkg::num_t     rem_reg  [Stages-1];
    logic [DivW-1:0]   div_reg  [Stages-1];

    for (genvar st = 0; st < Stages; st++)
    begin : g_stage
        localparam int Bit = Stages - 1 - st;

        logic            src_valid;
        edc_pkg::side_t  src_side;
        edc_pkg::num_t   src_rem;
        edc_pkg::quo_t   src_quo;
        logic [DivW-1:0] src_div;
        edc_pkg::num_t   rem_next;
        edc_pkg::quo_t   quo_next;
        logic [RemW-1:0] shifted;

        if (st == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_side  = in_side;
            assign src_rem   = in_num;
            assign src_quo   = '0;
            assign src_div   = in_div;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[st-1];
            assign src_side  = side_reg[st-1];
            assign src_rem   = rem_reg[st-1];
            assign src_quo   = quo_reg[st-1];
            assign src_div   = div_reg[st-1];
        end

        assign shifted = RemW'(src_div) << Bit;

        always_comb
        begin
            rem_next = src_rem;
            quo_next = src_quo;
            for (int l = 0; l < edc_pkg::LANES; l++)
            begin
                if (src_rem[l] >= shifted)
                begin
                    rem_next[l]      = src_rem[l] - shifted;
                    quo_next[l][Bit] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[st] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[st] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[st] <= src_side;
                quo_reg[st]  <= quo_next;
            end
        end

        if (st < Stages - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[st] <= rem_next;
                    div_reg[st] <= src_div;
                end
            end
        end
    end

    assign out_valid = valid_reg[Stages-1];
    assign out_side  = side_reg[Stages-1];
    assign out_quo   = quo_reg[Stages-1];
endmodule

[test/tb.sv]
// self-checking testbench for the elastic disc collision unit
typedef struct packed {
    logic [31:0] mass_first;
    logic [31:0] mass_second;
    logic [31:0] pos_first_x;
    logic [31:0] pos_first_y;
    logic [31:0] pos_second_x;
    logic [31:0] pos_second_y;
    logic [31:0] vel_first_x;
    logic [31:0] vel_first_y;
    logic [31:0] vel_second_x;
    logic [31:0] vel_second_y;
} disc_pair_t;

typedef struct packed {
    logic [31:0] new_first_x;
    logic [31:0] new_first_y;
    logic [31:0] new_second_x;
    logic [31:0] new_second_y;
    logic        impact_applied;
    logic        saturated;
} disc_velocities_t;

class collision_scoreboard;
    bit               approach_only = 1'b1;
    disc_velocities_t pending_velocities[$];
    int               errors = 0;

    // rounded share of the impulse: k * dot * dc / den, ties away from zero
    function automatic logic signed [199:0] velocity_change(logic signed [199:0] k,
            logic signed [199:0] dot, logic signed [199:0] dc, logic [199:0] den);
        logic signed [199:0] num;
        logic [199:0]        mag;
        logic [199:0]        quo;
        num = k * dot * dc;
        mag = (num < 0) ? -num : num;
        quo = (2 * mag + den) / (2 * den);
        return (num < 0) ? -$signed(quo) : $signed(quo);
    endfunction

    function automatic logic [31:0] clamp_word(logic signed [199:0] v, ref bit sat);
        if (v > 200'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -200'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic disc_velocities_t collide(disc_pair_t p);
        logic signed [199:0] dx, dy, v1x, v1y, v2x, v2y, dot, k1, k2;
        logic [199:0]        msum, dd, den;
        bit                  hit;
        bit                  sat;
        disc_velocities_t    r;
        dx   = $signed(p.pos_second_x) - $signed(p.pos_first_x);
        dy   = $signed(p.pos_second_y) - $signed(p.pos_first_y);
        v1x  = $signed(p.vel_first_x);
        v1y  = $signed(p.vel_first_y);
        v2x  = $signed(p.vel_second_x);
        v2y  = $signed(p.vel_second_y);
        dot  = (v2x - v1x) * dx + (v2y - v1y) * dy;
        msum = 200'(p.mass_first) + 200'(p.mass_second);
        hit  = (dx != 0 || dy != 0) && msum != 0 && (!approach_only || dot < 0);
        sat  = 1'b0;
        if (hit)
        begin
            dd  = dx * dx + dy * dy;
            den = msum * dd;
            k1  = 2 * $signed(200'(p.mass_second));
            k2  = 2 * $signed(200'(p.mass_first));
            v1x = v1x + velocity_change(k1, dot, dx, den);
            v1y = v1y + velocity_change(k1, dot, dy, den);
            v2x = v2x - velocity_change(k2, dot, dx, den);
            v2y = v2y - velocity_change(k2, dot, dy, den);
        end
        r.new_first_x    = clamp_word(v1x, sat);
        r.new_first_y    = clamp_word(v1y, sat);
        r.new_second_x   = clamp_word(v2x, sat);
        r.new_second_y   = clamp_word(v2y, sat);
        r.impact_applied = hit;
        r.saturated      = sat;
        return r;
    endfunction

    function void note_pair(disc_pair_t p);
        pending_velocities.push_back(collide(p));
    endfunction

    function void check_result(disc_velocities_t got);
        disc_velocities_t want;
        if (pending_velocities.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result %p", $time, got);
            return;
        end
        want = pending_velocities.pop_front();
        if (got !== want)
        begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
        end
    endfunction
endclass

module tb;
    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    bit   quiet;          // no idling on either side in the last part of the run
    int   cycles;

    edc_pair_if req ();
    edc_resp_if rsp ();

    collision_scoreboard sb = new();

    elastic_disc_collision_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 300000)
            begin
                $display("elastic_disc_collision_unit regression: fail");
                $finish;
            end
        end
    end

    // result side: random stall bursts, checks every completed transfer
    initial
    begin
        int stall;
        stall     = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                sb.check_result('{rsp.new_first_x, rsp.new_first_y, rsp.new_second_x,
                                  rsp.new_second_y, rsp.impact_applied, rsp.saturated});
            @(negedge clk);
            if (stall > 0)
                stall--;
            else if (!quiet && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 12);
            rsp.ready = (stall == 0);
        end
    end

    // word mix weighted towards extremes and small physical values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'($signed($urandom_range(0, 64)) - 32);
            3, 4:    return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            5:       return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return $urandom();
        endcase
    endfunction

    function automatic disc_pair_t random_pair();
        disc_pair_t p;
        p.mass_first   = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_word();
        p.mass_second  = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_word();
        p.pos_first_x  = pick_word();
        p.pos_first_y  = pick_word();
        p.pos_second_x = pick_word();
        p.pos_second_y = pick_word();
        p.vel_first_x  = pick_word();
        p.vel_first_y  = pick_word();
        p.vel_second_x = pick_word();
        p.vel_second_y = pick_word();
        // coincident centres now and then
        if ($urandom_range(0, 14) == 0)
        begin
            p.pos_second_x = p.pos_first_x;
            p.pos_second_y = p.pos_first_y;
        end
        return p;
    endfunction

    // one transfer on req; called and returns at a falling edge
    task automatic send_pair(disc_pair_t p);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        req.valid        = 1'b1;
        req.mass_first   = p.mass_first;
        req.mass_second  = p.mass_second;
        req.pos_first_x  = p.pos_first_x;
        req.pos_first_y  = p.pos_first_y;
        req.pos_second_x = p.pos_second_x;
        req.pos_second_y = p.pos_second_y;
        req.vel_first_x  = p.vel_first_x;
        req.vel_first_y  = p.vel_first_y;
        req.vel_second_x = p.vel_second_x;
        req.vel_second_y = p.vel_second_y;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_pair(p);
        @(negedge clk);
    endtask

    // wait for every outstanding result, then let the pipeline settle
    task automatic drain();
        req.valid = 1'b0;
        while (sb.pending_velocities.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_mode(bit approach);
        cfg_we    = 1'b1;
        cfg_wdata = approach;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.approach_only = approach;
    endtask

    task automatic random_phase(int count);
        repeat (count) send_pair(random_pair());
    endtask

    initial
    begin
        disc_pair_t directed[$];
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        quiet     = 1'b0;
        req.valid = 1'b0;
        {req.mass_first, req.mass_second, req.pos_first_x, req.pos_first_y,
         req.pos_second_x, req.pos_second_y, req.vel_first_x, req.vel_first_y,
         req.vel_second_x, req.vel_second_y} = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed pairs: masses, positions x/y, velocities x/y
        // all zero, coincident centres
        directed.push_back('{32'h1_0000, 32'h1_0000, 0, 0, 0, 0, 0, 0, 0, 0});
        directed.push_back('{32'h1_0000, 32'h2_0000, 32'h5_0000, 32'h3_0000,
                             32'h5_0000, 32'h3_0000, 32'h1_0000, 0, -32'sh1_0000, 0});
        // approach, head-on with equal masses, oblique with unequal masses
        directed.push_back('{32'h1_0000, 32'h1_0000, 0, 0, 32'h2_0000, 0,
                             32'h1_0000, 0, -32'sh1_0000, 0});
        directed.push_back('{32'h1_0000, 32'h3_0000, 0, 0, 32'h2_0000, 32'h2_0000,
                             32'h2_0000, 32'h1_0000, -32'sh1_0000, 0});
        // separating discs
        directed.push_back('{32'h1_0000, 32'h1_0000, 0, 0, 32'h2_0000, 0,
                             -32'sh1_0000, 0, 32'h1_0000, 0});
        // zero mass sum
        directed.push_back('{0, 0, 0, 0, 32'h2_0000, 0, 32'h1_0000, 0, -32'sh1_0000, 0});
        // one zero mass
        directed.push_back('{0, 32'h1_0000, 0, 0, 0, 32'h2_0000, 0, 32'h1_0000, 0, 0});
        // zero dot product, then a tiny approach with small rounded changes
        directed.push_back('{32'h1_0000, 32'h1_0000, 0, 0, 32'h7fff_ffff, 0,
                             0, 32'h7fff_ffff, 0, 32'h7fff_fffe});
        directed.push_back('{32'hffff_ffff, 32'h0000_0001, 0, 0, 1, 0, 1, 0, 0, 0});
        // extremes: saturation both ways
        directed.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000,
                             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h8000_0000, 32'h8000_0000});
        directed.push_back('{32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                             32'h7fff_ffff, 32'h8000_0000});
        directed.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                             32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                             32'hffff_ffff, 32'hffff_ffff});
        foreach (directed[i])
            send_pair(directed[i]);
        drain();

        // separating discs now take the impulse too
        write_mode(1'b0);
        foreach (directed[i])
            send_pair(directed[i]);
        random_phase(180);
        drain();

        write_mode(1'b1);
        random_phase(150);
        // sender holds off until every result is back, then resumes
        drain();
        random_phase(50);
        drain();

        // last part: both sides stream without idling
        write_mode(1'b0);
        quiet = 1'b1;
        random_phase(150);
        drain();

        if (sb.errors == 0)
            $display("elastic_disc_collision_unit regression: pass");
        else
            $display("elastic_disc_collision_unit regression: fail");
        $finish;
    end
endmodule
